// File: design/tcrq_pkg.sv
package tcrq_pkg;

  localparam int unsigned DEPTH_DEF = 1024;
  localparam int unsigned CHAR_W    = 8;
  localparam int unsigned ENTRY_W   = CHAR_W + 1;
  localparam int unsigned CNT_W     = 11;
  localparam int unsigned OP_W      = 3;

  typedef enum logic [OP_W-1:0] {
    OP_PUT   = 3'd0,
    OP_GET   = 3'd1,
    OP_UNPUT = 3'd2,
    OP_FLUSH = 3'd3,
    OP_SCAN  = 3'd4,
    OP_PEEK  = 3'd5
  } op_e;

  typedef struct packed {
    logic [OP_W-1:0]   opcode;
    logic [CHAR_W-1:0] char_in;
    logic              quote_in;
    logic [CNT_W-1:0]  amount;
    logic [CHAR_W-1:0] stop_mask;
    logic              stop_on_quote;
  } req_t;

  typedef struct packed {
    logic [CHAR_W-1:0] char_out;
    logic              quote_out;
    logic              ok;
    logic [CNT_W-1:0]  count_out;
    logic [CNT_W-1:0]  level;
  } res_t;

endpackage

// File: design/tty_char_ring_queue.sv
// Character ring queue with a per-entry quote bit.
// The input channel (in_valid_i / in_stall_o) carries one operation word:
// put, get, unput, flush, scan or peek with its operands. The output channel
// (out_valid_o / out_stall_i) returns exactly one result word per operation.
// The configuration channel (cfg_valid_i / cfg_ready_o) writes quote_enable;
// it is always ready.
// Items are handled one at a time; a new operation is taken only in idle.
// Put, flush and refused operations go straight to the done state. Get, unput
// and peek pass through a read state because the store has a registered read
// port. Scan walks one entry per step, up to DEPTH entries, on the same
// read port and index adder. The result word is registered into the output
// as the core returns to idle, so it may still wait in the output register
// while the next operation runs.
// When the receiver stalls, the output register holds its word and the
// core finishes the next operation and then waits until the register frees.
// Reset empties the queue, sets quote_enable to 1 and leaves the character
// store contents undefined; no clearing pass is needed.
module tty_char_ring_queue #(
  parameter int unsigned DEPTH = tcrq_pkg::DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  opcode_i,
  input  logic [7:0]  char_in_i,
  input  logic        quote_in_i,
  input  logic [10:0] amount_i,
  input  logic [7:0]  stop_mask_i,
  input  logic        stop_on_quote_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  char_out_o,
  output logic        quote_out_o,
  output logic        ok_o,
  output logic [10:0] count_out_o,
  output logic [10:0] level_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_wdata_i
);
  import tcrq_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);

  logic               quote_en_q;
  logic               out_valid_q;
  res_t               out_q;
  req_t               req;
  res_t               res;
  logic               req_ready;
  logic               res_valid;
  logic               res_take;
  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic [ENTRY_W-1:0] mem_wdata;
  logic               mem_re;
  logic [AW-1:0]      mem_raddr;
  logic [ENTRY_W-1:0] mem_rdata;

  assign req = '{opcode: opcode_i, char_in: char_in_i, quote_in: quote_in_i,
                 amount: amount_i, stop_mask: stop_mask_i,
                 stop_on_quote: stop_on_quote_i};

  assign res_take = res_valid && (!out_valid_q || !out_stall_i);

  tcrq_ctrl #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .quote_en_i  (quote_en_q),
    .req_valid_i (in_valid_i),
    .req_ready_o (req_ready),
    .req_i       (req),
    .res_valid_o (res_valid),
    .res_take_i  (res_take),
    .res_o       (res),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  tcrq_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quote_en_q  <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        quote_en_q <= cfg_wdata_i;
      end
      if (res_take) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_take) begin
      out_q <= res;
    end
  end

  assign in_stall_o  = !req_ready;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign char_out_o  = out_q.char_out;
  assign quote_out_o = out_q.quote_out;
  assign ok_o        = out_q.ok;
  assign count_out_o = out_q.count_out;
  assign level_o     = out_q.level;

endmodule

// File: design/tcrq_mem.sv
module tcrq_mem #(
  parameter int unsigned DEPTH = tcrq_pkg::DEPTH_DEF,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic                         clk_i,
  input  logic                         we_i,
  input  logic [AW-1:0]                waddr_i,
  input  logic [tcrq_pkg::ENTRY_W-1:0] wdata_i,
  input  logic                         re_i,
  input  logic [AW-1:0]                raddr_i,
  output logic [tcrq_pkg::ENTRY_W-1:0] rdata_o
);
  import tcrq_pkg::*;

  logic [ENTRY_W-1:0] mem_q [DEPTH];
  logic [ENTRY_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: design/tcrq_ctrl.sv
module tcrq_ctrl #(
  parameter int unsigned DEPTH = tcrq_pkg::DEPTH_DEF,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         quote_en_i,
  input  logic                         req_valid_i,
  output logic                         req_ready_o,
  input  tcrq_pkg::req_t               req_i,
  output logic                         res_valid_o,
  input  logic                         res_take_i,
  output tcrq_pkg::res_t               res_o,
  output logic                         mem_we_o,
  output logic [AW-1:0]                mem_waddr_o,
  output logic [tcrq_pkg::ENTRY_W-1:0] mem_wdata_o,
  output logic                         mem_re_o,
  output logic [AW-1:0]                mem_raddr_o,
  input  logic [tcrq_pkg::ENTRY_W-1:0] mem_rdata_i
);
  import tcrq_pkg::*;

  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned SW = AW + 1;
  localparam int unsigned WW = (CW > CNT_W) ? CW : CNT_W;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_READ = 4'b0010,
    S_SCAN = 4'b0100,
    S_DONE = 4'b1000
  } state_e;

  state_e            state_q, state_d;
  logic [AW-1:0]     head_q, head_d;
  logic [AW-1:0]     tail_q, tail_d;
  logic [CW-1:0]     fill_q, fill_d;
  logic [AW-1:0]     pos_q, pos_d;
  logic [CW-1:0]     left_q, left_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic [CHAR_W-1:0] mask_q, mask_d;
  logic              sq_q, sq_d;
  res_t              res_q, res_d;

  logic [SW-1:0]     add_a, add_b, add_s;
  logic [AW-1:0]     add_w;
  logic [CW-1:0]     flush_cnt;
  logic [AW-1:0]     tail_dec;
  logic              fill_zero;
  logic              fill_full;
  logic              peek_in;

  assign fill_zero = (fill_q == '0);
  assign fill_full = (fill_q == CW'(DEPTH));
  assign peek_in   = (WW'(req_i.amount) < WW'(fill_q));
  assign flush_cnt = (WW'(req_i.amount) < WW'(fill_q)) ? CW'(req_i.amount) : fill_q;
  assign tail_dec  = (tail_q == '0) ? AW'(DEPTH - 1) : tail_q - 1'b1;

  // Shared index adder with a single wrap correction.
  always_comb begin
    add_a = SW'(head_q);
    add_b = SW'(1);
    if (state_q == S_SCAN) begin
      add_a = SW'(pos_q);
    end else begin
      case (req_i.opcode)
        OP_PUT: begin
          add_a = fill_zero ? '0 : SW'(tail_q);
        end
        OP_FLUSH: begin
          add_b = SW'(flush_cnt);
        end
        OP_PEEK: begin
          add_b = SW'(req_i.amount);
        end
        default: begin
          add_b = SW'(1);
        end
      endcase
    end
  end

  assign add_s = add_a + add_b;
  assign add_w = (add_s >= SW'(DEPTH)) ? AW'(add_s - SW'(DEPTH)) : AW'(add_s);

  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    tail_d      = tail_q;
    fill_d      = fill_q;
    pos_d       = pos_q;
    left_d      = left_q;
    cnt_d       = cnt_q;
    mask_d      = mask_q;
    sq_d        = sq_q;
    res_d       = res_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = fill_zero ? '0 : tail_q;
    mem_wdata_o = {req_i.quote_in & quote_en_i, req_i.char_in};
    mem_re_o    = 1'b0;
    mem_raddr_o = head_q;
    case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          res_d   = '0;
          state_d = S_DONE;
          case (req_i.opcode)
            OP_PUT: begin
              if (!fill_full) begin
                mem_we_o = 1'b1;
                tail_d   = add_w;
                fill_d   = fill_q + 1'b1;
                if (fill_zero) begin
                  head_d = '0;
                end
                res_d.ok = 1'b1;
              end
            end
            OP_GET: begin
              if (!fill_zero) begin
                mem_re_o = 1'b1;
                head_d   = add_w;
                fill_d   = fill_q - 1'b1;
                state_d  = S_READ;
              end
            end
            OP_UNPUT: begin
              if (!fill_zero) begin
                mem_re_o    = 1'b1;
                mem_raddr_o = tail_dec;
                tail_d      = tail_dec;
                fill_d      = fill_q - 1'b1;
                state_d     = S_READ;
              end
            end
            OP_FLUSH: begin
              head_d          = add_w;
              fill_d          = fill_q - flush_cnt;
              res_d.ok        = 1'b1;
              res_d.count_out = CNT_W'(flush_cnt);
            end
            OP_SCAN: begin
              res_d.ok = 1'b1;
              if (!fill_zero) begin
                mem_re_o = 1'b1;
                pos_d    = head_q;
                left_d   = fill_q;
                cnt_d    = '0;
                mask_d   = req_i.stop_mask;
                sq_d     = req_i.stop_on_quote;
                state_d  = S_SCAN;
              end
            end
            OP_PEEK: begin
              if (peek_in) begin
                mem_re_o    = 1'b1;
                mem_raddr_o = add_w;
                state_d     = S_READ;
              end
            end
            default: begin
              res_d.ok = 1'b0;
            end
          endcase
        end
      end
      S_READ: begin
        res_d.char_out  = mem_rdata_i[CHAR_W-1:0];
        res_d.quote_out = mem_rdata_i[CHAR_W] & quote_en_i;
        res_d.ok        = 1'b1;
        state_d         = S_DONE;
      end
      S_SCAN: begin
        if (((mem_rdata_i[CHAR_W-1:0] & mask_q) != '0) ||
            (sq_q && mem_rdata_i[CHAR_W] && quote_en_i)) begin
          state_d = S_DONE;
        end else begin
          cnt_d           = cnt_q + 1'b1;
          left_d          = left_q - 1'b1;
          res_d.count_out = CNT_W'(cnt_d);
          if ((left_q == CW'(1)) || (pos_q == AW'(DEPTH - 1))) begin
            state_d = S_DONE;
          end else begin
            pos_d       = add_w;
            mem_re_o    = 1'b1;
            mem_raddr_o = add_w;
          end
        end
      end
      S_DONE: begin
        if (res_take_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
    if (fill_d == '0) begin
      head_d = '0;
      tail_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      head_q  <= '0;
      tail_q  <= '0;
      fill_q  <= '0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      fill_q  <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q  <= pos_d;
    left_q <= left_d;
    cnt_q  <= cnt_d;
    mask_q <= mask_d;
    sq_q   <= sq_d;
    res_q  <= res_d;
  end

  assign req_ready_o = (state_q == S_IDLE);
  assign res_valid_o = (state_q == S_DONE);

  always_comb begin
    res_o       = res_q;
    res_o.level = CNT_W'(fill_q);
  end

  a_empty_home: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q == '0 |-> head_q == '0 && tail_q == '0)
    else $error("empty queue with nonzero index");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CW'(DEPTH))
    else $error("fill above depth");

  a_scan_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SCAN |-> left_q != '0 && $stable(fill_q))
    else $error("scan walked past the data or state moved");

  a_full_put: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_IDLE && req_valid_i && req_i.opcode == OP_PUT && fill_full
    |=> fill_q == CW'(DEPTH) && !res_q.ok)
    else $error("put on full queue changed state");

endmodule

// File: verif/tb.sv
`timescale 1ns / 100ps

module tb;
  import tcrq_pkg::*;

  localparam int unsigned RING_DEPTH   = DEPTH_DEF;
  localparam int unsigned LONG_HOLD    = 300;
  localparam int unsigned LIMIT_CYCLES = 4_000_000;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [2:0]  opcode_i;
  logic [7:0]  char_in_i;
  logic        quote_in_i;
  logic [10:0] amount_i;
  logic [7:0]  stop_mask_i;
  logic        stop_on_quote_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [7:0]  char_out_o;
  logic        quote_out_o;
  logic        ok_o;
  logic [10:0] count_out_o;
  logic [10:0] level_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic        cfg_wdata_i;

  tty_char_ring_queue DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .opcode_i       (opcode_i),
    .char_in_i      (char_in_i),
    .quote_in_i     (quote_in_i),
    .amount_i       (amount_i),
    .stop_mask_i    (stop_mask_i),
    .stop_on_quote_i(stop_on_quote_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .char_out_o     (char_out_o),
    .quote_out_o    (quote_out_o),
    .ok_o           (ok_o),
    .count_out_o    (count_out_o),
    .level_o        (level_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_wdata_i    (cfg_wdata_i)
  );

  // Shadow copy of the queue state.
  logic [7:0]  ring_chars [RING_DEPTH];
  logic        ring_quotes [RING_DEPTH];
  int unsigned ring_head;
  int unsigned ring_tail;
  int unsigned ring_fill;
  logic        quote_en;

  res_t        awaited_replies [$];
  int unsigned burst_left    = 0;
  bit          long_hold_req = 1'b0;
  int unsigned cycle_count   = 0;
  int unsigned mismatch_count = 0;
  int unsigned words_sent    = 0;
  int unsigned replies_seen  = 0;
  int unsigned scans_sent    = 0;
  int unsigned refused_ops   = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic res_t ring_apply(req_t w);
    res_t        r;
    int unsigned pos;
    int unsigned left;
    int unsigned cnt;
    r = '0;
    cnt = 0;
    case (w.opcode)
      OP_PUT: if (ring_fill < RING_DEPTH) begin
        if (ring_fill == 0) begin
          ring_head = 0;
          ring_tail = 0;
        end
        ring_chars[ring_tail] = w.char_in;
        ring_quotes[ring_tail] = quote_en & w.quote_in;
        ring_tail = (ring_tail + 1) % RING_DEPTH;
        ring_fill++;
        r.ok = 1'b1;
      end
      OP_GET: if (ring_fill != 0) begin
        r.char_out = ring_chars[ring_head];
        r.quote_out = quote_en & ring_quotes[ring_head];
        ring_head = (ring_head + 1) % RING_DEPTH;
        ring_fill--;
        r.ok = 1'b1;
      end
      OP_UNPUT: if (ring_fill != 0) begin
        ring_tail = (ring_tail == 0) ? RING_DEPTH - 1 : ring_tail - 1;
        r.char_out = ring_chars[ring_tail];
        r.quote_out = quote_en & ring_quotes[ring_tail];
        ring_fill--;
        r.ok = 1'b1;
      end
      OP_FLUSH: begin
        cnt = (w.amount < ring_fill) ? w.amount : ring_fill;
        ring_head = (ring_head + cnt) % RING_DEPTH;
        ring_fill -= cnt;
        r.ok = 1'b1;
      end
      OP_SCAN: begin
        pos = ring_head;
        left = ring_fill;
        while (left != 0) begin
          if ((ring_chars[pos] & w.stop_mask) != 0) break;
          if (w.stop_on_quote && (quote_en & ring_quotes[pos])) break;
          cnt++;
          left--;
          pos++;
          if (pos >= RING_DEPTH) break;
        end
        r.ok = 1'b1;
      end
      OP_PEEK: if (w.amount < ring_fill) begin
        pos = (ring_head + w.amount) % RING_DEPTH;
        r.char_out = ring_chars[pos];
        r.quote_out = quote_en & ring_quotes[pos];
        r.ok = 1'b1;
      end
      default: ;
    endcase
    if (ring_fill == 0) begin
      ring_head = 0;
      ring_tail = 0;
    end
    r.count_out = CNT_W'(cnt);
    r.level = CNT_W'(ring_fill);
    return r;
  endfunction

  function automatic req_t op_word(op_e op, int unsigned ch, bit q, int unsigned amt,
                                   int unsigned mask, bit soq);
    req_t w;
    w.opcode = op;
    w.char_in = 8'(ch);
    w.quote_in = q;
    w.amount = 11'(amt);
    w.stop_mask = 8'(mask);
    w.stop_on_quote = soq;
    return w;
  endfunction

  function automatic req_t rand_word();
    int unsigned pick;
    int unsigned put_share;
    int unsigned ch;
    int unsigned amt;
    int unsigned mask;
    op_e         op;
    put_share = (ring_fill > 40) ? 20 : (ring_fill < 4) ? 55 : 35;
    pick = $urandom_range(0, 99);
    if (pick < put_share) op = OP_PUT;
    else if (pick < put_share + 18) op = OP_GET;
    else if (pick < put_share + 28) op = OP_UNPUT;
    else if (pick < put_share + 36) op = OP_FLUSH;
    else if (pick < put_share + 52) op = OP_SCAN;
    else op = OP_PEEK;
    ch = ($urandom_range(0, 1) == 1) ? $urandom_range(0, 15) : $urandom_range(0, 255);
    case ($urandom_range(0, 4))
      0: mask = 0;
      1: mask = 8'hff;
      2: mask = 1 << $urandom_range(0, 7);
      3: mask = 8'hf0;
      default: mask = $urandom_range(0, 255);
    endcase
    amt = $urandom_range(0, 1024);
    if (op == OP_FLUSH && $urandom_range(0, 3) != 0) begin
      amt = ($urandom_range(0, 7) == 0) ? 1024 : $urandom_range(0, 4);
    end
    if (op == OP_PEEK && $urandom_range(0, 4) != 0) begin
      amt = (ring_fill > 0) ? $urandom_range(0, ring_fill - 1) : 0;
    end else if (op == OP_PEEK && $urandom_range(0, 1) == 1) begin
      amt = ring_fill;
    end
    return op_word(op, ch, 1'($urandom_range(0, 1)), amt, mask,
                   1'($urandom_range(0, 1)));
  endfunction

  task automatic send_word(input req_t w);
    res_t want;
    in_valid_i <= 1'b1;
    opcode_i <= w.opcode;
    char_in_i <= w.char_in;
    quote_in_i <= w.quote_in;
    amount_i <= w.amount;
    stop_mask_i <= w.stop_mask;
    stop_on_quote_i <= w.stop_on_quote;
    do @(posedge clk_i); while (in_stall_o);
    want = ring_apply(w);
    awaited_replies.push_back(want);
    words_sent++;
    if (w.opcode == OP_SCAN) scans_sent++;
    if (!want.ok) refused_ops++;
  endtask

  task automatic issue(input req_t w);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap != 0 && $urandom_range(0, 3) != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    send_word(w);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (awaited_replies.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_quote_enable(input logic value);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_wdata_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    quote_en = value;
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic test_directed();
    issue(op_word(OP_SCAN, 0, 0, 0, 8'h00, 0));
    issue(op_word(OP_GET, 0, 0, 0, 0, 0));
    issue(op_word(OP_UNPUT, 0, 0, 0, 0, 0));
    issue(op_word(OP_PEEK, 0, 0, 0, 0, 0));
    issue(op_word(OP_FLUSH, 0, 0, 5, 0, 0));
    issue(op_word(OP_PUT, 8'h00, 0, 0, 0, 0));
    issue(op_word(OP_PUT, 8'hff, 1, 0, 0, 0));
    issue(op_word(OP_PUT, 8'h01, 0, 0, 0, 0));
    issue(op_word(OP_PUT, 8'h80, 1, 0, 0, 0));
    issue(op_word(OP_PEEK, 0, 0, 0, 0, 0));
    issue(op_word(OP_PEEK, 0, 0, 3, 0, 0));
    issue(op_word(OP_PEEK, 0, 0, 4, 0, 0));
    issue(op_word(OP_PEEK, 0, 0, 1024, 0, 0));
    issue(op_word(OP_SCAN, 0, 0, 0, 8'h00, 0));
    issue(op_word(OP_SCAN, 0, 0, 0, 8'h00, 1));
    issue(op_word(OP_SCAN, 0, 0, 0, 8'hff, 0));
    issue(op_word(OP_SCAN, 0, 0, 0, 8'h02, 0));
    issue(op_word(OP_GET, 0, 0, 0, 0, 0));
    issue(op_word(OP_UNPUT, 0, 0, 0, 0, 0));
    issue(op_word(OP_FLUSH, 0, 0, 0, 0, 0));
    issue(op_word(OP_FLUSH, 0, 0, 1024, 0, 0));
    issue(op_word(OP_PUT, 8'h55, 1, 0, 0, 0));
    issue(op_word(OP_UNPUT, 0, 0, 0, 0, 0));
    drain();
  endtask

  // Fills the store, then moves the head near the physical end so that
  // the data wraps and a scan has to stop at the last index.
  task automatic test_full_and_wrap();
    for (int unsigned i = 0; i < RING_DEPTH; i++) begin
      issue(op_word(OP_PUT, $urandom_range(0, 255), 1'($urandom_range(0, 1)), 0, 0, 0));
    end
    issue(op_word(OP_PUT, 8'h7e, 1, 0, 0, 0));
    issue(op_word(OP_PEEK, 0, 0, RING_DEPTH - 1, 0, 0));
    issue(op_word(OP_PEEK, 0, 0, 1024, 0, 0));
    issue(op_word(OP_SCAN, 0, 0, 0, 8'h00, 0));
    issue(op_word(OP_FLUSH, 0, 0, 1000, 0, 0));
    issue(op_word(OP_UNPUT, 0, 0, 0, 0, 0));
    for (int unsigned i = 0; i < 6; i++) begin
      issue(op_word(OP_PUT, $urandom_range(0, 255), 1'($urandom_range(0, 1)), 0, 0, 0));
    end
    issue(op_word(OP_SCAN, 0, 0, 0, 8'h00, 0));
    issue(op_word(OP_PEEK, 0, 0, 25, 0, 0));
    issue(op_word(OP_GET, 0, 0, 0, 0, 0));
    issue(op_word(OP_FLUSH, 0, 0, 1024, 0, 0));
    drain();
  endtask

  task automatic test_quote_config();
    issue(op_word(OP_PUT, 8'h41, 1, 0, 0, 0));
    write_quote_enable(1'b0);
    issue(op_word(OP_PEEK, 0, 0, 0, 0, 0));
    issue(op_word(OP_PUT, 8'h42, 1, 0, 0, 0));
    issue(op_word(OP_SCAN, 0, 0, 0, 8'h00, 1));
    write_quote_enable(1'b1);
    issue(op_word(OP_PEEK, 0, 0, 0, 0, 0));
    issue(op_word(OP_PEEK, 0, 0, 1, 0, 0));
    issue(op_word(OP_SCAN, 0, 0, 0, 8'h00, 1));
    issue(op_word(OP_GET, 0, 0, 0, 0, 0));
    issue(op_word(OP_UNPUT, 0, 0, 0, 0, 0));
    drain();
  endtask

  // The receiver holds off for a long stretch while words keep coming,
  // so the block has to stall its input.
  task automatic test_backpressure();
    long_hold_req = 1'b1;
    for (int i = 0; i < 40; i++) send_word(rand_word());
    drain();
  endtask

  task automatic test_random();
    for (int phase = 0; phase < 4; phase++) begin
      write_quote_enable(1'($urandom_range(0, 1)));
      for (int i = 0; i < 100; i++) issue(rand_word());
      drain();
    end
    write_quote_enable(1'b1);
  endtask

  initial begin : receiver
    int unsigned stretch;
    int unsigned style;
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_stall_i <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk_i);
      end else begin
        stretch = $urandom_range(1, 32);
        style = $urandom_range(0, 3);
        repeat (stretch) begin
          case (style)
            0: out_stall_i <= 1'b0;
            1: out_stall_i <= ($urandom_range(0, 3) == 0);
            2: out_stall_i <= ($urandom_range(0, 1) == 1);
            default: out_stall_i <= ($urandom_range(0, 3) != 0);
          endcase
          @(posedge clk_i);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    res_t got;
    res_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got.char_out = char_out_o;
      got.quote_out = quote_out_o;
      got.ok = ok_o;
      got.count_out = count_out_o;
      got.level = level_o;
      replies_seen++;
      if (awaited_replies.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("[%0t] Result word with nothing outstanding: char=%h quote=%b ok=%b "
                   , $time, got.char_out, got.quote_out, got.ok,
                   "count=%0d level=%0d", got.count_out, got.level);
        end
      end else begin
        want = awaited_replies.pop_front();
        if (got.char_out !== want.char_out || got.quote_out !== want.quote_out ||
            got.ok !== want.ok || got.count_out !== want.count_out ||
            got.level !== want.level) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("[%0t] Mismatch: expected char=%h quote=%b ok=%b count=%0d level=%0d",
                     $time, want.char_out, want.quote_out, want.ok, want.count_out,
                     want.level);
            $display("[%0t]           actual   char=%h quote=%b ok=%b count=%0d level=%0d",
                     $time, got.char_out, got.quote_out, got.ok, got.count_out,
                     got.level);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("Timeout after %0d cycles with %0d results outstanding.", cycle_count,
               awaited_replies.size());
      $display("tb NOT OK");
      $finish;
    end
  end

  initial begin : main
    rst_ni <= 1'b0;
    in_valid_i <= 1'b0;
    opcode_i <= '0;
    char_in_i <= '0;
    quote_in_i <= 1'b0;
    amount_i <= '0;
    stop_mask_i <= '0;
    stop_on_quote_i <= 1'b0;
    cfg_valid_i <= 1'b0;
    cfg_wdata_i <= 1'b0;
    ring_head = 0;
    ring_tail = 0;
    ring_fill = 0;
    quote_en = 1'b1;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_full_and_wrap();
    test_quote_config();
    test_backpressure();
    test_random();
    drain();
    repeat (20) @(posedge clk_i);
    $display("Sent %0d operations (%0d scans, %0d refused), checked %0d results, %0d mismatches.",
             words_sent, scans_sent, refused_ops, replies_seen, mismatch_count);
    $display("Run covered empty and full queue, wrap at the store end, quote bit on and off.");
    if (mismatch_count == 0 && awaited_replies.size() == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

// File: filelist.f
design/tcrq_pkg.sv
design/tcrq_mem.sv
design/tcrq_ctrl.sv
design/tty_char_ring_queue.sv
verif/tb.sv
